// File: src/sac_pkg.sv
// Shared types and constants for the sliding anagram counter.
`default_nettype none

package sac_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int MAX_PATTERN_DEF = 64;
    localparam int ALPHABET_DEF    = 26;

    // Fixed field widths
    localparam int OPCODE_W = 2;
    localparam int LETTER_W = 5;
    localparam int TOTAL_W  = 32;
    localparam int IN_DATA_W = 8;
    // window_match + match_total + pattern_overflow, ahead of pattern_size
    localparam int OUT_FIXED_W = 1 + TOTAL_W + 1;
    // Wide enough to compare a letter against any alphabet size up to 511
    localparam int CMP_W = 9;

    // Item kinds carried on the input tuser
    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2
    } t_opcode;

    // Per-transaction commands from the control path to the histogram bank
    typedef struct packed {
        logic                clear;
        logic                pat_add;
        logic                txt_up;
        logic                txt_down;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] gone;
    } t_hist_ctl;

endpackage

`default_nettype wire

// File: src/sac_ring.sv
// Circular letter buffer holding recent text letters, with write-to-read bypass.
`default_nettype none

module sac_ring #(
    parameter int MAX_PATTERN = sac_pkg::MAX_PATTERN_DEF,
    parameter int LEN_W       = 7,
    parameter int AW          = 6
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_wr_en,
    input  wire logic [AW-1:0]                i_wr_ptr,
    input  wire logic [sac_pkg::LETTER_W-1:0] i_wr_letter,
    input  wire logic                         i_rd_en,
    input  wire logic [AW-1:0]                i_rd_ptr,
    input  wire logic [LEN_W-1:0]             i_rd_len,
    output logic      [sac_pkg::LETTER_W-1:0] o_gone
);
    import sac_pkg::*;

    localparam int SUM_W = LEN_W + 1;

    logic [LETTER_W-1:0] mem [MAX_PATTERN];
    logic [LETTER_W-1:0] r_rd_data;
    logic [LETTER_W-1:0] r_byp_data;
    logic                r_byp;
    logic [SUM_W-1:0]    rd_sum;
    logic [AW-1:0]       rd_addr;

    // Letter that leaves the window: len entries behind the write pointer
    always_comb begin
        rd_sum = SUM_W'(i_rd_ptr) + SUM_W'(MAX_PATTERN) - SUM_W'(i_rd_len);
        if (rd_sum >= SUM_W'(MAX_PATTERN)) begin
            rd_sum = rd_sum - SUM_W'(MAX_PATTERN);
        end
        rd_addr = rd_sum[AW-1:0];
    end

    // Storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_ptr] <= i_wr_letter;
        end
        if (i_rd_en) begin
            r_rd_data  <= mem[rd_addr];
            r_byp_data <= i_wr_letter;
        end
    end

    // Same-cycle write to the read address takes the new letter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (rd_addr == i_wr_ptr);
        end
    end

    assign o_gone = r_byp ? r_byp_data : r_rd_data;

endmodule

`default_nettype wire

// File: src/sac_hist.sv
// Pattern and window histograms with the differing-letter tally.
`default_nettype none

module sac_hist #(
    parameter int ALPHABET = sac_pkg::ALPHABET_DEF,
    parameter int LEN_W    = 7
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sac_pkg::t_hist_ctl i_ctl,
    output logic                    o_tally_zero
);
    import sac_pkg::*;

    localparam int TW = $clog2(ALPHABET + 1);

    logic [LEN_W-1:0]    r_pat [ALPHABET];
    logic [LEN_W-1:0]    r_win [ALPHABET];
    logic [LEN_W-1:0]    n_pat [ALPHABET];
    logic [LEN_W-1:0]    n_win [ALPHABET];
    logic [ALPHABET-1:0] hit_pat, hit_up, hit_dn;
    logic [ALPHABET-1:0] gain, loss, fresh;
    logic [TW-1:0]       r_tally, n_tally;
    logic [TW-1:0]       r_distinct, n_distinct;
    logic [TW-1:0]       gain_cnt, loss_cnt;

    // Per-letter cell update
    always_comb begin
        for (int i = 0; i < ALPHABET; i++) begin
            hit_pat[i] = i_ctl.pat_add  && (CMP_W'(i_ctl.letter) == CMP_W'(i));
            hit_up[i]  = i_ctl.txt_up   && (CMP_W'(i_ctl.letter) == CMP_W'(i));
            hit_dn[i]  = i_ctl.txt_down && (CMP_W'(i_ctl.gone) == CMP_W'(i));

            n_pat[i] = i_ctl.clear ? '0 : r_pat[i] + LEN_W'(hit_pat[i]);

            if (i_ctl.clear || i_ctl.pat_add) begin
                n_win[i] = '0;
            end else if (hit_up[i] && !hit_dn[i]) begin
                n_win[i] = r_win[i] + LEN_W'(1);
            end else if (hit_dn[i] && !hit_up[i]) begin
                n_win[i] = r_win[i] - LEN_W'(1);
            end else begin
                n_win[i] = r_win[i];
            end

            gain[i]  = (r_win[i] == r_pat[i]) && (n_win[i] != r_pat[i]);
            loss[i]  = (r_win[i] != r_pat[i]) && (n_win[i] == r_pat[i]);
            fresh[i] = hit_pat[i] && (r_pat[i] == '0);
        end
    end

    // At most two cells change per text letter, so a count is 0, 1 or 2
    always_comb begin
        gain_cnt = (|(gain & (gain - 1'b1))) ? TW'(2) : TW'(|gain);
        loss_cnt = (|(loss & (loss - 1'b1))) ? TW'(2) : TW'(|loss);

        n_distinct = i_ctl.clear ? '0 : r_distinct + TW'(|fresh);

        if (i_ctl.clear) begin
            n_tally = '0;
        end else if (i_ctl.pat_add) begin
            // Window restarts empty: every letter present in the pattern differs
            n_tally = n_distinct;
        end else begin
            n_tally = r_tally + gain_cnt - loss_cnt;
        end
    end

    assign o_tally_zero = (n_tally == '0);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ALPHABET; i++) begin
                r_pat[i] <= '0;
                r_win[i] <= '0;
            end
            r_tally    <= '0;
            r_distinct <= '0;
        end else begin
            for (int i = 0; i < ALPHABET; i++) begin
                r_pat[i] <= n_pat[i];
                r_win[i] <= n_win[i];
            end
            r_tally    <= n_tally;
            r_distinct <= n_distinct;
        end
    end

endmodule

`default_nettype wire

// File: src/sliding_anagram_counter_top.sv
// Sliding-window anagram counter: input register, update logic, result register.
// An accepted transaction passes the input register, then the result register.
// One transaction per cycle while results are taken; the input register and
// the result register are separate, so one more item is taken while a result waits.
// Reset (synchronous, active low) empties both registers and clears the pattern,
// window, tally, running total and overflow flag; no clearing pass is needed.
`default_nettype none

module sliding_anagram_counter_top #(
    parameter int  MAX_PATTERN = sac_pkg::MAX_PATTERN_DEF,
    parameter int  ALPHABET    = sac_pkg::ALPHABET_DEF,
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1),
    localparam int OUT_W       = ((sac_pkg::OUT_FIXED_W + LEN_W + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [sac_pkg::IN_DATA_W-1:0] i_s_tdata,  // letter
    input  wire logic [sac_pkg::OPCODE_W-1:0]  i_s_tuser,  // opcode
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // window_match, match_total, pattern_overflow, pattern_size
    output logic      [OUT_W-1:0]              o_m_tdata
);
    import sac_pkg::*;

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [AW-1:0] PTR_LAST = AW'(MAX_PATTERN - 1);

    // Input register
    logic                r_in_vld;
    logic [OPCODE_W-1:0] r_in_op;
    logic [LETTER_W-1:0] r_in_letter;

    // Block state
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_fill, n_fill;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_ovf, n_ovf;
    logic [AW-1:0]      r_ptr, n_ptr;

    // Result register
    logic               r_out_vld;
    logic               r_out_match;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_ovf;
    logic [LEN_W-1:0]   r_out_len;

    logic advance, in_ready, load;
    logic letter_ok, is_clr, is_pat, is_txt, pat_add, pat_full, win_full;
    logic match, tally_zero;
    logic [LETTER_W-1:0] gone;
    t_hist_ctl hist_ctl;

    // Handshake: the held item moves on when the result register is free
    assign advance    = r_in_vld && (!r_out_vld || i_m_tready);
    assign in_ready   = !r_in_vld || advance;
    assign load       = i_s_tvalid && in_ready;
    assign o_s_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_op     <= i_s_tuser;
            r_in_letter <= i_s_tdata[LETTER_W-1:0];
        end
    end

    // Item decode
    always_comb begin
        letter_ok = CMP_W'(r_in_letter) < CMP_W'(ALPHABET);
        is_clr    = (r_in_op == OP_CLEAR);
        is_pat    = (r_in_op == OP_PATTERN) && letter_ok;
        is_txt    = (r_in_op == OP_TEXT) && letter_ok && (r_len != '0);
        pat_add   = is_pat && (r_len < LEN_W'(MAX_PATTERN));
        pat_full  = is_pat && !pat_add;
        win_full  = (r_fill >= r_len);
    end

    // Commands to the histogram bank, only on a moving transaction
    always_comb begin
        hist_ctl.clear    = advance && is_clr;
        hist_ctl.pat_add  = advance && pat_add;
        hist_ctl.txt_up   = advance && is_txt;
        hist_ctl.txt_down = advance && is_txt && win_full;
        hist_ctl.letter   = r_in_letter;
        hist_ctl.gone     = gone;
    end

    sac_hist #(
        .ALPHABET (ALPHABET),
        .LEN_W    (LEN_W)
    ) u_hist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (hist_ctl),
        .o_tally_zero (tally_zero)
    );

    // Next state and match decision
    always_comb begin
        n_len   = r_len;
        n_fill  = r_fill;
        n_total = r_total;
        n_ovf   = r_ovf;
        n_ptr   = r_ptr;
        match   = 1'b0;
        priority if (is_clr) begin
            n_len   = '0;
            n_fill  = '0;
            n_total = '0;
            n_ovf   = 1'b0;
            n_ptr   = '0;
        end else if (pat_add) begin
            n_len  = r_len + LEN_W'(1);
            n_fill = '0;
        end else if (pat_full) begin
            n_ovf = 1'b1;
        end else if (is_txt) begin
            if (!win_full) begin
                n_fill = r_fill + LEN_W'(1);
            end
            n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + AW'(1);
            match = (n_fill == r_len) && tally_zero;
            if (match && (r_total != '1)) begin
                n_total = r_total + TOTAL_W'(1);
            end
        end else begin
            // ignored letters and the unused opcode leave the state alone
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_fill  <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_ptr   <= '0;
        end else if (advance) begin
            r_len   <= n_len;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_ovf   <= n_ovf;
            r_ptr   <= n_ptr;
        end
    end

    // Letter buffer; the leaving letter is fetched as the item enters the
    // input register, using the state as it stands after this edge
    sac_ring #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W),
        .AW          (AW)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (advance && is_txt),
        .i_wr_ptr    (r_ptr),
        .i_wr_letter (r_in_letter),
        .i_rd_en     (load),
        .i_rd_ptr    (advance ? n_ptr : r_ptr),
        .i_rd_len    (advance ? n_len : r_len),
        .o_gone      (gone)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_match <= match;
            r_out_total <= n_total;
            r_out_ovf   <= n_ovf;
            r_out_len   <= n_len;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_W'({r_out_len, r_out_ovf, r_out_total, r_out_match});

endmodule

`default_nettype wire

// File: src/sac_checker.sv
// Port-level assertions for the sliding anagram counter, bound to the top level.
`default_nettype none

module sac_checker #(
    parameter int  MAX_PATTERN = sac_pkg::MAX_PATTERN_DEF,
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1),
    localparam int OUT_W       = ((sac_pkg::OUT_FIXED_W + LEN_W + 7) / 8) * 8
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] i_m_tdata
);
    import sac_pkg::*;

    logic               res_match;
    logic [TOTAL_W-1:0] res_total;
    logic [LEN_W-1:0]   res_size;

    assign res_match = i_m_tdata[0];
    assign res_total = i_m_tdata[TOTAL_W:1];
    assign res_size  = i_m_tdata[OUT_FIXED_W +: LEN_W];

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // A waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result changed while stalled");

    // Pattern never grows past its limit
    a_size_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> res_size <= LEN_W'(MAX_PATTERN))
        else $error("pattern size beyond limit");

    // A match needs a loaded pattern and a nonzero total
    a_match_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && res_match |-> (res_size != '0) && (res_total != '0))
        else $error("match with empty pattern or zero total");

endmodule

bind sliding_anagram_counter_top sac_checker #(
    .MAX_PATTERN (MAX_PATTERN)
) u_sac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire
